@@ hdl/msup_pkg.sv @@
// Shared types, codes and reset constants for the motion safety supervisor.
package msup_pkg;

	localparam int CFG_DATA_W = 16;
	localparam int CFG_IDX_W  = 2;

	localparam logic [CFG_IDX_W-1:0] CFG_OBSTACLE_STOP = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_HB_TIMEOUT    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_TICK_PERIOD   = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_STRIKE_LIMIT  = 2'd3;

	localparam logic [12:0] OBSTACLE_STOP_RST = 13'd200;
	localparam logic [15:0] HB_TIMEOUT_RST    = 16'd5000;
	localparam logic [9:0]  TICK_PERIOD_RST   = 10'd50;
	localparam logic [3:0]  STRIKE_LIMIT_RST  = 4'd3;

	localparam logic [1:0] ACT_SAMPLE  = 2'd0;
	localparam logic [1:0] ACT_COMMAND = 2'd1;
	localparam logic [1:0] ACT_TICK    = 2'd2;
	localparam logic [1:0] ACT_FAULT   = 2'd3;

	localparam logic [3:0] CMD_FWD         = 4'd0;
	localparam logic [3:0] CMD_BACK        = 4'd1;
	localparam logic [3:0] CMD_LEFT        = 4'd2;
	localparam logic [3:0] CMD_RIGHT       = 4'd3;
	localparam logic [3:0] CMD_STOP        = 4'd4;
	localparam logic [3:0] CMD_SCAN        = 4'd5;
	localparam logic [3:0] CMD_SCAN_AT     = 4'd6;
	localparam logic [3:0] CMD_FAULT_CLEAR = 4'd7;
	localparam logic [3:0] CMD_PING        = 4'd8;
	localparam logic [3:0] CMD_STATUS      = 4'd9;
	localparam logic [3:0] CMD_HELLO       = 4'd10;

	localparam logic [2:0] RPL_NONE     = 3'd0;
	localparam logic [2:0] RPL_OK       = 3'd1;
	localparam logic [2:0] RPL_OBSTACLE = 3'd2;
	localparam logic [2:0] RPL_FAULT    = 3'd3;
	localparam logic [2:0] RPL_READY    = 3'd4;
	localparam logic [2:0] RPL_PONG     = 3'd5;

	localparam logic [2:0] DRV_HALT   = 3'd0;
	localparam logic [2:0] DRV_FWD    = 3'd1;
	localparam logic [2:0] DRV_REV    = 3'd2;
	localparam logic [2:0] DRV_TURN_L = 3'd3;
	localparam logic [2:0] DRV_TURN_R = 3'd4;

	localparam logic [3:0]  STRIKE_MAX = 4'd15;
	localparam logic [15:0] AGE_MAX    = 16'hFFFF;
	localparam logic [14:0] ANGLE_MAX  = 15'd180;

	typedef struct packed {
		logic [12:0] obstacle_stop_mm;
		logic [15:0] hb_limit_ms;
		logic [9:0]  tick_period_ms;
		logic [3:0]  strike_limit;
	} cfg_t;

	typedef struct packed {
		logic [1:0]  action;
		logic        echo_timeout;
		logic [12:0] distance_mm;
		logic [3:0]  command_code;
		logic [15:0] angle_arg;
	} item_t;

	typedef struct packed {
		logic [2:0]  direction;
		logic        path_ok;
		logic        fault;
		logic [12:0] stored_distance;
		logic        stored_timeout;
		logic [3:0]  strike_count;
		logic [15:0] heartbeat_age;
		logic        warned;
		logic        fault_seen;
		logic        prev_clear;
		logic        scan_latched;
	} state_t;

	typedef struct packed {
		logic [2:0]  reply_code;
		logic [2:0]  drive_direction;
		logic        path_is_clear;
		logic        fault_active;
		logic        heartbeat_lost_event;
		logic        fault_stop_event;
		logic        obstacle_event;
		logic        sweep_scan_request;
		logic        targeted_scan_request;
		logic [7:0]  scan_angle;
		logic [12:0] last_distance_mm;
		logic        last_was_timeout;
	} result_t;

	localparam state_t STATE_RST = '{
		direction:       DRV_HALT,
		path_ok:         1'b0,
		fault:           1'b0,
		stored_distance: 13'd0,
		stored_timeout:  1'b1,
		strike_count:    4'd0,
		heartbeat_age:   16'd0,
		warned:          1'b0,
		fault_seen:      1'b0,
		prev_clear:      1'b1,
		scan_latched:    1'b0
	};

endpackage

@@ hdl/msup_cfg.sv @@
// Configuration register file of the motion safety supervisor.
module msup_cfg
	import msup_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output cfg_t                  cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.obstacle_stop_mm <= OBSTACLE_STOP_RST;
			cfg_q.hb_limit_ms      <= HB_TIMEOUT_RST;
			cfg_q.tick_period_ms   <= TICK_PERIOD_RST;
			cfg_q.strike_limit     <= STRIKE_LIMIT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_OBSTACLE_STOP: cfg_q.obstacle_stop_mm <= cfg_data[12:0];
				CFG_HB_TIMEOUT:    cfg_q.hb_limit_ms      <= cfg_data;
				CFG_TICK_PERIOD:   cfg_q.tick_period_ms   <= cfg_data[9:0];
				CFG_STRIKE_LIMIT:  cfg_q.strike_limit     <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

@@ hdl/msup_step.sv @@
// Next-state and result logic for one supervisor item.
module msup_step
	import msup_pkg::*;
(
	input  cfg_t    cfg,
	input  state_t  st,
	input  item_t   item,
	output state_t  st_nxt,
	output result_t res
);

	always_comb begin
		state_t      n;
		logic [2:0]  reply;
		logic [7:0]  angle;
		logic        hb_ev;
		logic        fault_ev;
		logic        obs_ev;
		logic        sweep;
		logic        target;
		logic        moving;
		logic [16:0] age_sum;
		logic [3:0]  strikes;

		n        = st;
		reply    = RPL_NONE;
		angle    = 8'd0;
		hb_ev    = 1'b0;
		fault_ev = 1'b0;
		obs_ev   = 1'b0;
		sweep    = 1'b0;
		target   = 1'b0;
		moving   = 1'b0;
		age_sum  = {1'b0, st.heartbeat_age} + {7'd0, cfg.tick_period_ms};
		strikes  = (st.strike_count < STRIKE_MAX) ? st.strike_count + 4'd1 : st.strike_count;

		case (item.action)
			ACT_SAMPLE: begin
				if (item.echo_timeout) begin
					n.strike_count = strikes;
					if (strikes >= cfg.strike_limit)
						n.path_ok = 1'b1;
					n.stored_distance = 13'd0;
					n.stored_timeout  = 1'b1;
				end else begin
					if (item.distance_mm != 13'd0) begin
						n.strike_count = 4'd0;
						n.path_ok      = item.distance_mm > cfg.obstacle_stop_mm;
					end else begin
						n.path_ok = 1'b0;
					end
					n.stored_distance = item.distance_mm;
					n.stored_timeout  = 1'b0;
				end
			end
			ACT_COMMAND: begin
				case (item.command_code)
					CMD_FWD: begin
						if (st.fault) begin
							n.direction = DRV_HALT;
							reply = RPL_FAULT;
						end else if (!st.path_ok) begin
							n.direction = DRV_HALT;
							reply = RPL_OBSTACLE;
						end else begin
							n.direction = DRV_FWD;
							reply = RPL_OK;
						end
					end
					CMD_BACK, CMD_LEFT, CMD_RIGHT: begin
						if (st.fault) begin
							n.direction = DRV_HALT;
							reply = RPL_FAULT;
						end else begin
							n.direction = item.command_code[2:0] + 3'd1;
							reply = RPL_OK;
						end
					end
					CMD_STOP: begin
						n.direction = DRV_HALT;
						reply = RPL_OK;
					end
					CMD_SCAN: begin
						sweep = 1'b1;
						reply = RPL_OK;
					end
					CMD_SCAN_AT: begin
						if (item.angle_arg[15])
							angle = 8'd0;
						else if (item.angle_arg[14:0] > ANGLE_MAX)
							angle = ANGLE_MAX[7:0];
						else
							angle = item.angle_arg[7:0];
						target = 1'b1;
						reply = RPL_OK;
					end
					CMD_FAULT_CLEAR: begin
						n.fault = 1'b0;
						n.direction = DRV_HALT;
						reply = RPL_OK;
					end
					CMD_PING: begin
						n.heartbeat_age = 16'd0;
						reply = RPL_PONG;
					end
					CMD_HELLO: reply = RPL_READY;
					default: ;
				endcase
			end
			ACT_TICK: begin
				n.heartbeat_age = age_sum[16] ? AGE_MAX : age_sum[15:0];
				if (n.heartbeat_age > cfg.hb_limit_ms) begin
					if (!st.warned) begin
						hb_ev = 1'b1;
						n.warned = 1'b1;
					end
					n.direction = DRV_HALT;
				end else begin
					n.warned = 1'b0;
				end
				if (st.fault && !st.fault_seen) begin
					fault_ev = 1'b1;
					n.direction = DRV_HALT;
				end
				n.fault_seen = st.fault;
				moving = (n.direction == DRV_FWD) || (n.direction == DRV_TURN_L) ||
					(n.direction == DRV_TURN_R);
				if (moving && !st.path_ok) begin
					obs_ev = st.prev_clear;
					n.direction = DRV_HALT;
					if (!st.scan_latched) begin
						sweep = 1'b1;
						n.scan_latched = 1'b1;
					end
				end else begin
					n.scan_latched = 1'b0;
				end
				n.prev_clear = st.path_ok;
			end
			default: n.fault = 1'b1;
		endcase

		st_nxt = n;
		res.reply_code            = reply;
		res.drive_direction       = n.direction;
		res.path_is_clear         = n.path_ok;
		res.fault_active          = n.fault;
		res.heartbeat_lost_event  = hb_ev;
		res.fault_stop_event      = fault_ev;
		res.obstacle_event        = obs_ev;
		res.sweep_scan_request    = sweep;
		res.targeted_scan_request = target;
		res.scan_angle            = angle;
		res.last_distance_mm      = n.stored_distance;
		res.last_was_timeout      = n.stored_timeout;
	end

endmodule

@@ hdl/motion_safety_supervisor.sv @@
// Top level of the motion safety supervisor: input stage, state and result register.
//
//  channel   handshake                 payload
//  input     in_valid / in_ready       action, echo_timeout, distance_mm, command_code, angle_arg
//  output    out_valid / out_ready     reply_code ... last_was_timeout
//  config    cfg_we (no wait)          cfg_index, cfg_data
//
// One item per cycle sustained while the output is not stalled; an accepted item is held in
// the input stage register, then loaded into the result register, from which it transfers.
// The input stage is processed against the state registers in one pass and the
// result is registered; state updates in the same edge.
// A stalled output holds the input stage; in_ready follows out_ready combinationally.
// Reset (arst_n low) returns all state and configuration to their defaults at once.
module motion_safety_supervisor
	import msup_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [1:0]            action,
	input  logic                  echo_timeout,
	input  logic [12:0]           distance_mm,
	input  logic [3:0]            command_code,
	input  logic signed [15:0]    angle_arg,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [2:0]            reply_code,
	output logic [2:0]            drive_direction,
	output logic                  path_is_clear,
	output logic                  fault_active,
	output logic                  heartbeat_lost_event,
	output logic                  fault_stop_event,
	output logic                  obstacle_event,
	output logic                  sweep_scan_request,
	output logic                  targeted_scan_request,
	output logic [7:0]            scan_angle,
	output logic [12:0]           last_distance_mm,
	output logic                  last_was_timeout,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cfg_t    cfg;
	item_t   item_s1;
	logic    valid_s1;
	state_t  state_q;
	state_t  state_nxt;
	result_t res_nxt;
	result_t res_s2;
	logic    valid_s2;
	logic    adv_s1;

	msup_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	msup_step u_step (
		.cfg    (cfg),
		.st     (state_q),
		.item   (item_s1),
		.st_nxt (state_nxt),
		.res    (res_nxt)
	);

	assign adv_s1   = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			state_q  <= STATE_RST;
		end else begin
			if (in_ready)
				valid_s1 <= in_valid;
			if (adv_s1) begin
				valid_s2 <= 1'b1;
				state_q  <= state_nxt;
			end else if (out_ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1.action       <= action;
			item_s1.echo_timeout <= echo_timeout;
			item_s1.distance_mm  <= distance_mm;
			item_s1.command_code <= command_code;
			item_s1.angle_arg    <= angle_arg;
		end
		if (adv_s1)
			res_s2 <= res_nxt;
	end

	assign out_valid             = valid_s2;
	assign reply_code            = res_s2.reply_code;
	assign drive_direction       = res_s2.drive_direction;
	assign path_is_clear         = res_s2.path_is_clear;
	assign fault_active          = res_s2.fault_active;
	assign heartbeat_lost_event  = res_s2.heartbeat_lost_event;
	assign fault_stop_event      = res_s2.fault_stop_event;
	assign obstacle_event        = res_s2.obstacle_event;
	assign sweep_scan_request    = res_s2.sweep_scan_request;
	assign targeted_scan_request = res_s2.targeted_scan_request;
	assign scan_angle            = res_s2.scan_angle;
	assign last_distance_mm      = res_s2.last_distance_mm;
	assign last_was_timeout      = res_s2.last_was_timeout;

endmodule

@@ tb/msup_checker.sv @@
// Checker for the motion safety supervisor: predicts each reply from accepted items and compares.
`timescale 1ns / 1ps

module msup_checker
	import msup_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic                  in_ready,
	input  logic [1:0]            action,
	input  logic                  echo_timeout,
	input  logic [12:0]           distance_mm,
	input  logic [3:0]            command_code,
	input  logic signed [15:0]    angle_arg,
	input  logic                  out_valid,
	input  logic                  out_ready,
	input  logic [2:0]            reply_code,
	input  logic [2:0]            drive_direction,
	input  logic                  path_is_clear,
	input  logic                  fault_active,
	input  logic                  heartbeat_lost_event,
	input  logic                  fault_stop_event,
	input  logic                  obstacle_event,
	input  logic                  sweep_scan_request,
	input  logic                  targeted_scan_request,
	input  logic [7:0]            scan_angle,
	input  logic [12:0]           last_distance_mm,
	input  logic                  last_was_timeout,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output int                    mismatches,
	output int                    outstanding
);

	logic [12:0] stop_mm;
	logic [15:0] hb_limit_ms;
	logic [9:0]  tick_ms;
	logic [3:0]  strikes_needed;

	logic [2:0]  dir_now;
	logic        clear_now;
	logic        fault_now;
	logic [12:0] dist_seen;
	logic        timeout_seen;
	logic [3:0]  strikes;
	logic [15:0] age_ms;
	logic        hb_warned;
	logic        fault_was;
	logic        clear_was;
	logic        sweep_done;

	result_t predicted_replies[$];

	task automatic step_supervisor(
		input  logic [1:0]         act,
		input  logic               tmo,
		input  logic [12:0]        smp_mm,
		input  logic [3:0]         cmd,
		input  logic signed [15:0] ang,
		output result_t            r
	);
		logic [16:0] sum;
		logic        moving;
		int          deg;
		r = '0;
		case (act)
			ACT_SAMPLE: begin
				if (tmo) begin
					if (strikes != STRIKE_MAX)
						strikes = strikes + 4'd1;
					if (strikes >= strikes_needed)
						clear_now = 1'b1;
					dist_seen    = '0;
					timeout_seen = 1'b1;
				end else begin
					if (smp_mm != '0) begin
						strikes   = '0;
						clear_now = smp_mm > stop_mm;
					end else begin
						clear_now = 1'b0;
					end
					dist_seen    = smp_mm;
					timeout_seen = 1'b0;
				end
			end
			ACT_COMMAND: begin
				case (cmd)
					CMD_FWD: begin
						if (fault_now) begin
							dir_now      = DRV_HALT;
							r.reply_code = RPL_FAULT;
						end else if (!clear_now) begin
							dir_now      = DRV_HALT;
							r.reply_code = RPL_OBSTACLE;
						end else begin
							dir_now      = DRV_FWD;
							r.reply_code = RPL_OK;
						end
					end
					CMD_BACK, CMD_LEFT, CMD_RIGHT: begin
						if (fault_now) begin
							dir_now      = DRV_HALT;
							r.reply_code = RPL_FAULT;
						end else begin
							dir_now = (cmd == CMD_BACK) ? DRV_REV :
							          (cmd == CMD_LEFT) ? DRV_TURN_L : DRV_TURN_R;
							r.reply_code = RPL_OK;
						end
					end
					CMD_STOP: begin
						dir_now      = DRV_HALT;
						r.reply_code = RPL_OK;
					end
					CMD_SCAN: begin
						r.sweep_scan_request = 1'b1;
						r.reply_code         = RPL_OK;
					end
					CMD_SCAN_AT: begin
						deg = ang;
						if (deg < 0)
							deg = 0;
						if (deg > int'(ANGLE_MAX))
							deg = int'(ANGLE_MAX);
						r.scan_angle            = 8'(deg);
						r.targeted_scan_request = 1'b1;
						r.reply_code            = RPL_OK;
					end
					CMD_FAULT_CLEAR: begin
						fault_now    = 1'b0;
						dir_now      = DRV_HALT;
						r.reply_code = RPL_OK;
					end
					CMD_PING: begin
						age_ms       = '0;
						r.reply_code = RPL_PONG;
					end
					CMD_HELLO: r.reply_code = RPL_READY;
					default: ;
				endcase
			end
			ACT_TICK: begin
				sum    = {1'b0, age_ms} + {7'd0, tick_ms};
				age_ms = (sum > {1'b0, AGE_MAX}) ? AGE_MAX : sum[15:0];
				if (age_ms > hb_limit_ms) begin
					if (!hb_warned) begin
						r.heartbeat_lost_event = 1'b1;
						hb_warned              = 1'b1;
					end
					dir_now = DRV_HALT;
				end else begin
					hb_warned = 1'b0;
				end
				if (fault_now && !fault_was) begin
					r.fault_stop_event = 1'b1;
					dir_now            = DRV_HALT;
				end
				fault_was = fault_now;
				moving = (dir_now == DRV_FWD) || (dir_now == DRV_TURN_L) ||
					(dir_now == DRV_TURN_R);
				if (moving && !clear_now) begin
					if (clear_was)
						r.obstacle_event = 1'b1;
					dir_now = DRV_HALT;
					if (!sweep_done) begin
						r.sweep_scan_request = 1'b1;
						sweep_done           = 1'b1;
					end
				end else begin
					sweep_done = 1'b0;
				end
				clear_was = clear_now;
			end
			default: fault_now = 1'b1;
		endcase
		r.drive_direction  = dir_now;
		r.path_is_clear    = clear_now;
		r.fault_active     = fault_now;
		r.last_distance_mm = dist_seen;
		r.last_was_timeout = timeout_seen;
	endtask

	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		result_t want;
		if (!arst_n) begin
			stop_mm        = OBSTACLE_STOP_RST;
			hb_limit_ms    = HB_TIMEOUT_RST;
			tick_ms        = TICK_PERIOD_RST;
			strikes_needed = STRIKE_LIMIT_RST;
			dir_now        = STATE_RST.direction;
			clear_now      = STATE_RST.path_ok;
			fault_now      = STATE_RST.fault;
			dist_seen      = STATE_RST.stored_distance;
			timeout_seen   = STATE_RST.stored_timeout;
			strikes        = STATE_RST.strike_count;
			age_ms         = STATE_RST.heartbeat_age;
			hb_warned      = STATE_RST.warned;
			fault_was      = STATE_RST.fault_seen;
			clear_was      = STATE_RST.prev_clear;
			sweep_done     = STATE_RST.scan_latched;
			predicted_replies.delete();
			mismatches  = 0;
			outstanding = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_OBSTACLE_STOP: stop_mm        = cfg_data[12:0];
					CFG_HB_TIMEOUT:    hb_limit_ms    = cfg_data[15:0];
					CFG_TICK_PERIOD:   tick_ms        = cfg_data[9:0];
					CFG_STRIKE_LIMIT:  strikes_needed = cfg_data[3:0];
					default: ;
				endcase
			end
			if (out_valid && out_ready) begin
				if (predicted_replies.size() == 0) begin
					$error("result transfer with no prediction pending");
					mismatches++;
				end else begin
					want = predicted_replies.pop_front();
					check_field("reply_code", want.reply_code, reply_code);
					check_field("drive_direction", want.drive_direction, drive_direction);
					check_field("path_is_clear", want.path_is_clear, path_is_clear);
					check_field("fault_active", want.fault_active, fault_active);
					check_field("heartbeat_lost_event", want.heartbeat_lost_event,
						heartbeat_lost_event);
					check_field("fault_stop_event", want.fault_stop_event, fault_stop_event);
					check_field("obstacle_event", want.obstacle_event, obstacle_event);
					check_field("sweep_scan_request", want.sweep_scan_request,
						sweep_scan_request);
					check_field("targeted_scan_request", want.targeted_scan_request,
						targeted_scan_request);
					check_field("scan_angle", want.scan_angle, scan_angle);
					check_field("last_distance_mm", want.last_distance_mm, last_distance_mm);
					check_field("last_was_timeout", want.last_was_timeout, last_was_timeout);
				end
			end
			if (in_valid && in_ready) begin
				step_supervisor(action, echo_timeout, distance_mm, command_code, angle_arg, want);
				predicted_replies.push_back(want);
			end
			outstanding = predicted_replies.size();
		end
	end

endmodule

@@ tb/tb_top.sv @@
// Testbench top for the motion safety supervisor: clock, reset, stimulus, back-pressure, verdict.
`timescale 1ns / 1ps

module tb_top;
	import msup_pkg::*;

	localparam int CYCLE_LIMIT  = 200000;
	localparam int PHASE_ITEMS  = 180;
	localparam int HOLD_CYCLES  = 300;

	logic                  clk;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_ready;
	logic [1:0]            action;
	logic                  echo_timeout;
	logic [12:0]           distance_mm;
	logic [3:0]            command_code;
	logic signed [15:0]    angle_arg;
	logic                  out_valid;
	logic                  out_ready;
	logic [2:0]            reply_code;
	logic [2:0]            drive_direction;
	logic                  path_is_clear;
	logic                  fault_active;
	logic                  heartbeat_lost_event;
	logic                  fault_stop_event;
	logic                  obstacle_event;
	logic                  sweep_scan_request;
	logic                  targeted_scan_request;
	logic [7:0]            scan_angle;
	logic [12:0]           last_distance_mm;
	logic                  last_was_timeout;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	int                    mismatches;
	int                    outstanding;

	bit hold_go;
	bit calm;
	int cur_stop;
	int tick_pct;
	int cycle_count;

	motion_safety_supervisor dut (.*);
	msup_checker u_checker (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin : watchdog
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("status: fail");
		$finish;
	end

	initial begin : receiver
		int  n;
		bit  held;
		held      = 1'b0;
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_go && !held) begin
				held = 1'b1;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end else if (!calm && $urandom_range(0, 5) == 0) begin
				out_ready <= 1'b0;
				n = $urandom_range(1, 11);
				repeat (n - 1) @(negedge clk);
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	function automatic item_t mk(logic [1:0] a, logic t, logic [12:0] d, logic [3:0] c,
		logic [15:0] g);
		item_t it;
		it.action       = a;
		it.echo_timeout = t;
		it.distance_mm  = d;
		it.command_code = c;
		it.angle_arg    = g;
		return it;
	endfunction

	function automatic item_t random_item();
		item_t it;
		int    pick;
		pick = $urandom_range(0, 99);
		if (pick < tick_pct)
			it.action = ACT_TICK;
		else if (pick < tick_pct + 5)
			it.action = ACT_FAULT;
		else if (pick < tick_pct + 5 + (95 - tick_pct) / 2)
			it.action = ACT_COMMAND;
		else
			it.action = ACT_SAMPLE;
		it.echo_timeout = ($urandom_range(0, 4) == 0);
		case ($urandom_range(0, 9))
			0:       it.distance_mm = '0;
			1, 2:    it.distance_mm = 13'($urandom);
			3:       it.distance_mm = 13'(cur_stop);
			default: it.distance_mm = 13'($urandom_range(0, cur_stop + 400));
		endcase
		if ($urandom_range(0, 9) < 4)
			it.command_code = 4'($urandom_range(0, 15));
		else
			it.command_code = 4'($urandom_range(CMD_FWD, CMD_RIGHT));
		case ($urandom_range(0, 3))
			0:       it.angle_arg = 16'($urandom);
			1:       it.angle_arg = 16'($urandom_range(0, 200));
			2:       it.angle_arg = -16'($urandom_range(1, 40));
			default: it.angle_arg = 16'($urandom_range(150, 400));
		endcase
		return it;
	endfunction

	// called at a falling edge; returns at a falling edge
	task automatic send_item(input item_t it);
		in_valid     <= 1'b1;
		action       <= it.action;
		echo_timeout <= it.echo_timeout;
		distance_mm  <= it.distance_mm;
		command_code <= it.command_code;
		angle_arg    <= it.angle_arg;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
	endtask

	task automatic gap_maybe();
		if (!calm && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(negedge clk);
		end
	endtask

	task automatic send_paced(input item_t it);
		gap_maybe();
		send_item(it);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (outstanding != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic program_cfg(input logic [15:0] stop, hb, tick, strike);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_OBSTACLE_STOP;
		cfg_data  <= stop;
		@(negedge clk);
		cfg_index <= CFG_HB_TIMEOUT;
		cfg_data  <= hb;
		@(negedge clk);
		cfg_index <= CFG_TICK_PERIOD;
		cfg_data  <= tick;
		@(negedge clk);
		cfg_index <= CFG_STRIKE_LIMIT;
		cfg_data  <= strike;
		@(negedge clk);
		cfg_we <= 1'b0;
		cur_stop = stop[12:0];
	endtask

	initial begin : stimulus
		logic [15:0] stop, hb, tick, strike;
		arst_n       = 1'b0;
		in_valid     = 1'b0;
		action       = ACT_SAMPLE;
		echo_timeout = 1'b0;
		distance_mm  = '0;
		command_code = CMD_STOP;
		angle_arg    = '0;
		cfg_we       = 1'b0;
		cfg_index    = CFG_OBSTACLE_STOP;
		cfg_data     = '0;
		hold_go      = 1'b0;
		calm         = 1'b0;
		cur_stop     = OBSTACLE_STOP_RST;
		tick_pct     = 25;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed, reset configuration
		send_paced(mk(ACT_COMMAND, 1'b0, 13'd0, CMD_STATUS, 16'd0));
		send_paced(mk(ACT_COMMAND, 1'b0, 13'd0, CMD_FWD, 16'd0));
		send_paced(mk(ACT_COMMAND, 1'b0, 13'd0, CMD_HELLO, 16'd0));
		send_paced(mk(ACT_COMMAND, 1'b0, 13'd0, CMD_PING, 16'd0));
		send_paced(mk(ACT_SAMPLE, 1'b0, 13'h1FFF, CMD_STOP, 16'd0));
		send_paced(mk(ACT_COMMAND, 1'b0, 13'd0, CMD_FWD, 16'd0));
		send_paced(mk(ACT_TICK, 1'b0, 13'd0, CMD_FWD, 16'd0));
		send_paced(mk(ACT_SAMPLE, 1'b0, 13'(OBSTACLE_STOP_RST), CMD_FWD, 16'd0));
		send_paced(mk(ACT_TICK, 1'b0, 13'd0, CMD_FWD, 16'd0));
		send_paced(mk(ACT_SAMPLE, 1'b0, 13'(OBSTACLE_STOP_RST) + 13'd1, CMD_FWD, 16'd0));
		send_paced(mk(ACT_COMMAND, 1'b0, 13'd0, CMD_LEFT, 16'd0));
		send_paced(mk(ACT_TICK, 1'b0, 13'd0, CMD_FWD, 16'd0));
		send_paced(mk(ACT_SAMPLE, 1'b0, 13'd0, CMD_FWD, 16'd0));
		send_paced(mk(ACT_TICK, 1'b0, 13'd0, CMD_FWD, 16'd0));
		repeat (3) send_paced(mk(ACT_SAMPLE, 1'b1, 13'h1FFF, CMD_FWD, 16'd0));
		send_paced(mk(ACT_COMMAND, 1'b0, 13'd0, CMD_BACK, 16'd0));
		send_paced(mk(ACT_COMMAND, 1'b0, 13'd0, CMD_RIGHT, 16'd0));
		send_paced(mk(ACT_COMMAND, 1'b0, 13'd0, CMD_STOP, 16'd0));
		send_paced(mk(ACT_COMMAND, 1'b0, 13'd0, CMD_SCAN, 16'd0));
		send_paced(mk(ACT_COMMAND, 1'b0, 13'd0, CMD_SCAN_AT, 16'h8000));
		send_paced(mk(ACT_COMMAND, 1'b0, 13'd0, CMD_SCAN_AT, 16'h7FFF));
		send_paced(mk(ACT_COMMAND, 1'b0, 13'd0, CMD_SCAN_AT, 16'(ANGLE_MAX)));
		send_paced(mk(ACT_FAULT, 1'b0, 13'd0, CMD_FWD, 16'd0));
		send_paced(mk(ACT_COMMAND, 1'b0, 13'd0, CMD_FWD, 16'd0));
		send_paced(mk(ACT_TICK, 1'b0, 13'd0, CMD_FWD, 16'd0));
		send_paced(mk(ACT_COMMAND, 1'b0, 13'd0, CMD_FAULT_CLEAR, 16'd0));
		send_paced(mk(ACT_COMMAND, 1'b0, 13'd0, 4'hF, 16'd0));

		for (int phase = 0; phase < 5; phase++) begin
			drain();
			tick_pct = 25;
			case (phase)
				0: begin
					stop     = {3'($urandom), 13'h1FFF};
					hb       = 16'hFFFF;
					tick     = 16'd1000;
					strike   = 16'(STRIKE_MAX);
					tick_pct = 50;
				end
				1: begin
					stop   = 16'd0;
					hb     = 16'd1;
					tick   = 16'd1;
					strike = 16'd1;
				end
				2: begin
					stop   = 16'($urandom_range(100, 800));
					hb     = 16'($urandom_range(200, 1500));
					tick   = 16'($urandom_range(20, 200));
					strike = 16'($urandom_range(2, 6));
				end
				3: begin
					stop   = 16'($urandom_range(50, 400));
					hb     = 16'd0;
					tick   = 16'd0;
					strike = 16'd0;
				end
				default: begin
					stop   = 16'($urandom_range(200, 400));
					hb     = 16'($urandom_range(300, 2000));
					tick   = 16'($urandom_range(50, 250));
					strike = 16'($urandom_range(1, 4));
					calm   = 1'b1;
				end
			endcase
			program_cfg(stop, hb, tick, strike);
			if (phase == 0)
				hold_go = 1'b1;
			repeat (PHASE_ITEMS) send_paced(random_item());
		end

		drain();
		repeat (10) @(negedge clk);
		if (mismatches == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
